// ===== hdl/mlr_pkg.sv =====
// shared constants and control/status types for the midpoint line rasterizer
`timescale 1ns / 1ps
package mlr_pkg;

  // geometry limits
  localparam int COORD_BITS = 10;
  localparam int START_W    = COORD_BITS;
  localparam int END_W      = COORD_BITS + 1;
  localparam int PIX_W      = 11;
  localparam int MAX_DELTA  = 64;
  localparam int DELTA_W    = $clog2(MAX_DELTA + 1);
  localparam int DEC_W      = DELTA_W + 2;
  localparam int DIFF_W     = END_W + 1;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic zero_len;
    logic last_step;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/mlr_ctrl.sv =====
// controller state machine: sequences the load and per-pixel steps
`timescale 1ns / 1ps
module mlr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  mlr_pkg::status_t status,
  output mlr_pkg::cmd_t    cmd
);

  mlr_pkg::state_t state;
  mlr_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mlr_pkg::ST_IDLE: begin
        if (in_valid && !status.zero_len) begin
          state_next = mlr_pkg::ST_RUN;
        end
      end
      mlr_pkg::ST_RUN: begin
        if (status.out_free && status.last_step) begin
          state_next = mlr_pkg::ST_IDLE;
        end
      end
      default: state_next = mlr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = 1'b1;
    cmd.load = 1'b0;
    cmd.step = 1'b0;
    case (state)
      mlr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      mlr_pkg::ST_RUN: begin
        cmd.step = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== hdl/mlr_dp.sv =====
// datapath: delta clamping, decision update, pixel counters and output register
`timescale 1ns / 1ps
module mlr_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mlr_pkg::START_W-1:0] start_x,
  input  logic [mlr_pkg::START_W-1:0] start_y,
  input  logic [mlr_pkg::END_W-1:0]   end_x,
  input  logic [mlr_pkg::END_W-1:0]   end_y,
  input  mlr_pkg::cmd_t               cmd,
  output mlr_pkg::status_t            status,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mlr_pkg::PIX_W-1:0]   pixel_x,
  output logic [mlr_pkg::PIX_W-1:0]   pixel_y,
  output logic                        last_pixel
);

  logic [mlr_pkg::PIX_W-1:0]          cur_x;
  logic [mlr_pkg::PIX_W-1:0]          cur_y;
  logic signed [mlr_pkg::DEC_W-1:0]   decision;
  logic signed [mlr_pkg::DEC_W-1:0]   add_minor;
  logic signed [mlr_pkg::DEC_W-1:0]   add_both;
  logic [mlr_pkg::DELTA_W-1:0]        steps_left;
  logic                               steep_mode;

  logic signed [mlr_pkg::DIFF_W-1:0]  diff_x;
  logic signed [mlr_pkg::DIFF_W-1:0]  diff_y;
  logic [mlr_pkg::DELTA_W-1:0]        dx;
  logic [mlr_pkg::DELTA_W-1:0]        dy;
  logic [mlr_pkg::DELTA_W-1:0]        major;
  logic [mlr_pkg::DELTA_W-1:0]        minor;
  logic                               steep_in;

  // saturated deltas of the incoming beat
  always_comb begin
    diff_x = $signed({1'b0, end_x}) - $signed({2'b00, start_x});
    diff_y = $signed({1'b0, end_y}) - $signed({2'b00, start_y});
    if (diff_x <= 0) begin
      dx = '0;
    end else if (diff_x > mlr_pkg::DIFF_W'(mlr_pkg::MAX_DELTA)) begin
      dx = mlr_pkg::DELTA_W'(mlr_pkg::MAX_DELTA);
    end else begin
      dx = diff_x[mlr_pkg::DELTA_W-1:0];
    end
    if (diff_y <= 0) begin
      dy = '0;
    end else if (diff_y > mlr_pkg::DIFF_W'(mlr_pkg::MAX_DELTA)) begin
      dy = mlr_pkg::DELTA_W'(mlr_pkg::MAX_DELTA);
    end else begin
      dy = diff_y[mlr_pkg::DELTA_W-1:0];
    end
    steep_in = !(dy < dx);
    major    = steep_in ? dy : dx;
    minor    = steep_in ? dx : dy;
  end

  // status toward the controller
  always_comb begin
    status.zero_len  = (major == '0);
    status.last_step = (steps_left == mlr_pkg::DELTA_W'(1));
    status.out_free  = !out_valid || !out_stall;
  end

  // line state: load on accept, one midpoint step per pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      decision   <= '0;
      add_minor  <= '0;
      add_both   <= '0;
      steps_left <= '0;
      steep_mode <= 1'b0;
    end else if (cmd.load) begin
      cur_x      <= {1'b0, start_x};
      cur_y      <= {1'b0, start_y};
      steep_mode <= steep_in;
      steps_left <= major;
      decision   <= $signed({2'b00, minor}) - $signed({3'b000, major[mlr_pkg::DELTA_W-1:1]});
      add_minor  <= $signed({2'b00, minor});
      add_both   <= $signed({2'b00, minor}) - $signed({2'b00, major});
    end else if (cmd.step) begin
      steps_left <= steps_left - 1'b1;
      if (decision < 0) begin
        decision <= decision + add_minor;
      end else begin
        decision <= decision + add_both;
      end
      if (steep_mode) begin
        cur_y <= cur_y + 1'b1;
        if (decision >= 0) begin
          cur_x <= cur_x + 1'b1;
        end
      end else begin
        cur_x <= cur_x + 1'b1;
        if (decision >= 0) begin
          cur_y <= cur_y + 1'b1;
        end
      end
    end
  end

  // output beat register: holds the pixel after the step update
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      last_pixel <= (steps_left == mlr_pkg::DELTA_W'(1));
      if (steep_mode) begin
        pixel_y <= cur_y + 1'b1;
        pixel_x <= (decision >= 0) ? cur_x + 1'b1 : cur_x;
      end else begin
        pixel_x <= cur_x + 1'b1;
        pixel_y <= (decision >= 0) ? cur_y + 1'b1 : cur_y;
      end
    end
  end

endmodule

// ===== hdl/midpoint_line_rasterizer_top.sv =====
// Midpoint line rasterizer, first quadrant, one pixel beat per cycle unless the output stalls.
// An accepted line is loaded into the datapath and input stalls until its last step.
// A line of N steps (N = larger clamped delta, up to 64) emits N pixel beats; the step
// loop in the datapath registers one pixel beat per cycle unless stalled.
// A zero-length line is accepted and emits nothing.
// Reset (rst, synchronous, active high) returns the controller to idle and drops out_valid.
`timescale 1ns / 1ps
module midpoint_line_rasterizer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mlr_pkg::START_W-1:0] start_x,
  input  logic [mlr_pkg::START_W-1:0] start_y,
  input  logic [mlr_pkg::END_W-1:0]   end_x,
  input  logic [mlr_pkg::END_W-1:0]   end_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mlr_pkg::PIX_W-1:0]   pixel_x,
  output logic [mlr_pkg::PIX_W-1:0]   pixel_y,
  output logic                        last_pixel
);

  mlr_pkg::cmd_t    cmd;
  mlr_pkg::status_t status;

  // sequencing
  mlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and output beat
  mlr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel)
  );

endmodule
